### rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int DATA_W          = 16;
    localparam int STATUS_W        = 3;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int DEF_MAX_OWNERS  = 16;
    localparam int DEF_MAX_HOLES   = 17;
    localparam logic [DATA_W-1:0] MEM_SIZE_RESET = 16'd1024;

    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NO_FIT  = 3'd1;
    localparam status_t ST_UNKNOWN = 3'd2;
    localparam status_t ST_FULL    = 3'd3;
    localparam status_t ST_ZERO    = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_MEM_SIZE = 1'b1;

endpackage

### rtl/variable_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// First fit / best fit allocator over an address-ordered free table, with
// coalescing on release. One scan pointer walks the free table, another the owner table.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  s_      | s_command, s_request_size, s_proc_id    | command word in
//  m_      | m_status, m_result_id, m_base_addr,     | result word out
//          | m_block_size                            |
//  apb     | psel penable pwrite paddr pwdata prdata | fit_mode @0, memory_size @4
//
//  Allocate: a scan of the free table, plus a removal when a hole is used up.
//  Free: an owner lookup, then the position scan and table shift.
//  A result is held in the output register while the next word is taken.
//  Reset is synchronous: one free block [0, 1024), no owners, next id 1.
module variable_partition_allocator_unit #(
    parameter int MAX_OWNERS = vpa_pkg::DEF_MAX_OWNERS,
    parameter int MAX_HOLES  = vpa_pkg::DEF_MAX_HOLES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  vpa_pkg::data_t              s_request_size,
    input  vpa_pkg::data_t              s_proc_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output vpa_pkg::status_t            m_status,
    output vpa_pkg::data_t              m_result_id,
    output vpa_pkg::data_t              m_base_addr,
    output vpa_pkg::data_t              m_block_size,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpa_pkg::APB_AW-1:0]  paddr,
    input  logic [vpa_pkg::APB_DW-1:0]  pwdata,
    output logic [vpa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import vpa_pkg::*;

    localparam int HI_W = $clog2(MAX_HOLES);
    localparam int HC_W = $clog2(MAX_HOLES + 1);
    localparam int OI_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int OC_W = $clog2(MAX_OWNERS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FIT, S_OWN, S_POS, S_SHDN, S_SHUP, S_RESP
    } state_t;

    state_t                state_reg;
    logic                  fit_mode_reg;
    data_t                 mem_size_reg;
    data_t                 hole_start_reg [MAX_HOLES];
    data_t                 hole_len_reg   [MAX_HOLES];
    logic [HC_W-1:0]       hole_count_reg;
    data_t                 own_id_reg     [MAX_OWNERS];
    data_t                 own_start_reg  [MAX_OWNERS];
    data_t                 own_len_reg    [MAX_OWNERS];
    logic [MAX_OWNERS-1:0] own_valid_reg;
    data_t                 next_id_reg;

    data_t                 rsz_reg;
    data_t                 pid_reg;
    logic [OI_W-1:0]       slot_reg;
    logic [HC_W-1:0]       idx_reg;
    logic [HC_W-1:0]       pos_reg;
    logic [HC_W-1:0]       sel_reg;
    logic                  sel_found_reg;
    data_t                 sel_len_reg;
    data_t                 sel_start_reg;
    logic [OC_W-1:0]       oidx_reg;
    data_t                 blk_start_reg;
    data_t                 blk_len_reg;
    logic [DATA_W:0]       prev_end_reg;
    data_t                 prev_len_reg;

    status_t               res_status_reg;
    data_t                 res_id_reg;
    data_t                 res_start_reg;
    data_t                 res_size_reg;
    logic                  m_valid_reg;
    status_t               m_status_reg;
    data_t                 m_id_reg;
    data_t                 m_start_reg;
    data_t                 m_size_reg;

    logic [HC_W-1:0]       idx_p1;
    logic [HC_W-1:0]       idx_m1;
    logic [HC_W-1:0]       rd_cnt;
    logic [HI_W-1:0]       rd_idx;
    data_t                 rd_start;
    data_t                 rd_len;
    logic [OI_W-1:0]       oi;
    logic                  free_slot_found;
    logic [OI_W-1:0]       free_slot;
    logic                  cfg_wr;
    logic                  fit_done;
    logic                  below;
    logic                  above;

    assign idx_p1 = idx_reg + 1'b1;
    assign idx_m1 = idx_reg - 1'b1;
    assign oi     = oidx_reg[OI_W-1:0];

    always_comb begin
        unique case (state_reg)
            S_SHDN:  rd_cnt = idx_p1;
            S_SHUP:  rd_cnt = idx_m1;
            default: rd_cnt = idx_reg;
        endcase
    end

    assign rd_idx   = rd_cnt[HI_W-1:0];
    assign rd_start = hole_start_reg[rd_idx];
    assign rd_len   = hole_len_reg[rd_idx];

    always_comb begin
        free_slot_found = 1'b0;
        free_slot       = '0;
        for (int i = MAX_OWNERS - 1; i >= 0; i--) begin
            if (!own_valid_reg[i]) begin
                free_slot_found = 1'b1;
                free_slot       = OI_W'(i);
            end
        end
    end

    assign fit_done = (idx_reg >= hole_count_reg);
    assign below    = (idx_reg != '0) && (prev_end_reg == {1'b0, blk_start_reg});
    assign above    = (idx_reg < hole_count_reg) &&
                      (({1'b0, blk_start_reg} + {1'b0, blk_len_reg}) == {1'b0, rd_start});
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_result_id  = m_id_reg;
    assign m_base_addr  = m_start_reg;
    assign m_block_size = m_size_reg;
    assign pready       = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_FIT_MODE: prdata = {{(APB_DW-1){1'b0}}, fit_mode_reg};
            REG_MEM_SIZE: prdata = {{(APB_DW-DATA_W){1'b0}}, mem_size_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            fit_mode_reg      <= 1'b0;
            mem_size_reg      <= MEM_SIZE_RESET;
            hole_start_reg[0] <= '0;
            hole_len_reg[0]   <= MEM_SIZE_RESET;
            hole_count_reg    <= HC_W'(1);
            own_valid_reg     <= '0;
            next_id_reg       <= DATA_W'(1);
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_FIT_MODE) begin
                    fit_mode_reg <= pwdata[0];
                end else begin
                    mem_size_reg      <= pwdata[DATA_W-1:0];
                    hole_start_reg[0] <= '0;
                    hole_len_reg[0]   <= pwdata[DATA_W-1:0];
                    hole_count_reg    <= HC_W'(pwdata[DATA_W-1:0] != '0);
                    own_valid_reg     <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        rsz_reg        <= s_request_size;
                        pid_reg        <= s_proc_id;
                        res_status_reg <= ST_OK;
                        res_id_reg     <= '0;
                        res_start_reg  <= '0;
                        res_size_reg   <= '0;
                        idx_reg        <= '0;
                        oidx_reg       <= '0;
                        sel_found_reg  <= 1'b0;
                        if (s_command == CMD_FREE) begin
                            state_reg <= S_OWN;
                        end else if (s_request_size == '0) begin
                            res_status_reg <= ST_ZERO;
                            state_reg      <= S_RESP;
                        end else if (!free_slot_found) begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_RESP;
                        end else begin
                            slot_reg  <= free_slot;
                            state_reg <= S_FIT;
                        end
                    end
                end
                S_FIT: begin
                    if (fit_done) begin
                        if (!sel_found_reg) begin
                            res_status_reg <= ST_NO_FIT;
                            state_reg      <= S_RESP;
                        end else begin
                            own_valid_reg[slot_reg] <= 1'b1;
                            own_id_reg[slot_reg]    <= next_id_reg;
                            own_start_reg[slot_reg] <= sel_start_reg;
                            own_len_reg[slot_reg]   <= rsz_reg;
                            res_id_reg              <= next_id_reg;
                            res_start_reg           <= sel_start_reg;
                            res_size_reg            <= rsz_reg;
                            next_id_reg <= (next_id_reg == '1) ? DATA_W'(1)
                                                               : next_id_reg + 1'b1;
                            if (sel_len_reg == rsz_reg) begin
                                idx_reg   <= sel_reg;
                                state_reg <= S_SHDN;
                            end else begin
                                hole_start_reg[sel_reg[HI_W-1:0]] <= sel_start_reg + rsz_reg;
                                hole_len_reg[sel_reg[HI_W-1:0]]   <= sel_len_reg - rsz_reg;
                                state_reg <= S_RESP;
                            end
                        end
                    end else begin
                        idx_reg <= idx_p1;
                        if (rd_len >= rsz_reg) begin
                            if (!fit_mode_reg) begin
                                sel_reg       <= idx_reg;
                                sel_len_reg   <= rd_len;
                                sel_start_reg <= rd_start;
                                sel_found_reg <= 1'b1;
                                idx_reg       <= hole_count_reg;
                            end else if (!sel_found_reg || rd_len < sel_len_reg) begin
                                sel_reg       <= idx_reg;
                                sel_len_reg   <= rd_len;
                                sel_start_reg <= rd_start;
                                sel_found_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_OWN: begin
                    if (oidx_reg == OC_W'(MAX_OWNERS)) begin
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_RESP;
                    end else if (own_valid_reg[oi] && own_id_reg[oi] == pid_reg) begin
                        own_valid_reg[oi] <= 1'b0;
                        blk_start_reg     <= own_start_reg[oi];
                        blk_len_reg       <= own_len_reg[oi];
                        res_id_reg        <= pid_reg;
                        res_start_reg     <= own_start_reg[oi];
                        res_size_reg      <= own_len_reg[oi];
                        state_reg         <= S_POS;
                    end else begin
                        oidx_reg <= oidx_reg + 1'b1;
                    end
                end
                S_POS: begin
                    if (idx_reg < hole_count_reg && rd_start < blk_start_reg) begin
                        prev_end_reg <= {1'b0, rd_start} + {1'b0, rd_len};
                        prev_len_reg <= rd_len;
                        idx_reg      <= idx_p1;
                    end else if (below && above) begin
                        hole_len_reg[idx_m1[HI_W-1:0]] <= prev_len_reg + blk_len_reg + rd_len;
                        state_reg <= S_SHDN;
                    end else if (below) begin
                        hole_len_reg[idx_m1[HI_W-1:0]] <= prev_len_reg + blk_len_reg;
                        state_reg <= S_RESP;
                    end else if (above) begin
                        hole_start_reg[rd_idx] <= blk_start_reg;
                        hole_len_reg[rd_idx]   <= rd_len + blk_len_reg;
                        state_reg <= S_RESP;
                    end else if (hole_count_reg < HC_W'(MAX_HOLES)) begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= hole_count_reg;
                        state_reg <= S_SHUP;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                S_SHDN: begin
                    if (idx_p1 < hole_count_reg) begin
                        hole_start_reg[idx_reg[HI_W-1:0]] <= rd_start;
                        hole_len_reg[idx_reg[HI_W-1:0]]   <= rd_len;
                        idx_reg <= idx_p1;
                    end else begin
                        hole_count_reg <= hole_count_reg - 1'b1;
                        state_reg      <= S_RESP;
                    end
                end
                S_SHUP: begin
                    if (idx_reg > pos_reg) begin
                        hole_start_reg[idx_reg[HI_W-1:0]] <= rd_start;
                        hole_len_reg[idx_reg[HI_W-1:0]]   <= rd_len;
                        idx_reg <= idx_m1;
                    end else begin
                        hole_start_reg[idx_reg[HI_W-1:0]] <= blk_start_reg;
                        hole_len_reg[idx_reg[HI_W-1:0]]   <= blk_len_reg;
                        hole_count_reg <= hole_count_reg + 1'b1;
                        state_reg      <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_id_reg     <= res_id_reg;
                        m_start_reg  <= res_start_reg;
                        m_size_reg   <= res_size_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hole_count: assert property (@(posedge aclk) disable iff (!aresetn)
        hole_count_reg <= HC_W'(MAX_HOLES))
        else $error("free table count out of range");

    a_alloc_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIT && fit_done && sel_found_reg && !cfg_wr) |=>
        ($countones(own_valid_reg) == $past($countones(own_valid_reg)) + 1))
        else $error("allocate did not claim an owner slot");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg <= ST_ZERO))
        else $error("result status out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_id_reg == '0))
        else $error("error result carries an id");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the partition allocator against a behavioural prediction of its free
// and owner tables, under random valid/ready idling and several settings.
// ----------------------------------------------------------------------------
module tb_top;
    import vpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NOWN = DEF_MAX_OWNERS;
    localparam int NHOLE = DEF_MAX_HOLES;
    localparam int CYCLE_LIMIT = 900000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = CMD_ALLOC;
    data_t s_request_size = '0;
    data_t s_proc_id = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    data_t m_result_id, m_base_addr, m_block_size;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    typedef struct packed {
        status_t status;
        data_t id;
        data_t start;
        data_t size;
    } alloc_reply_t;

    alloc_reply_t replies_due[$];
    int errors = 0;
    int cycles = 0;
    bit stream_busy = 1'b0;

    // predicted allocator state
    logic fit_best;
    data_t mem_units;
    data_t hole_start[NHOLE];
    data_t hole_len[NHOLE];
    int hole_count;
    data_t own_id[NOWN];
    data_t own_start[NOWN];
    data_t own_len[NOWN];
    bit own_live[NOWN];
    data_t id_next;
    data_t live_ids[$];

    variable_partition_allocator_unit u_dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void wipe_tables();
        for (int i = 0; i < NOWN; i++) own_live[i] = 1'b0;
        hole_count = 0;
        if (mem_units != 0) begin
            hole_start[0] = '0;
            hole_len[0] = mem_units;
            hole_count = 1;
        end
        live_ids.delete();
    endfunction

    function automatic void drop_hole(int p);
        for (int i = p; i + 1 < hole_count; i++) begin
            hole_start[i] = hole_start[i+1];
            hole_len[i] = hole_len[i+1];
        end
        hole_count--;
    endfunction

    function automatic void return_hole(data_t s, data_t n);
        int p;
        bit lo, hi;
        p = 0;
        while (p < hole_count && hole_start[p] < s) p++;
        lo = (p > 0) && (17'(hole_start[p-1]) + hole_len[p-1] == 17'(s));
        hi = (p < hole_count) && (17'(s) + n == 17'(hole_start[p]));
        if (lo && hi) begin
            hole_len[p-1] = hole_len[p-1] + n + hole_len[p];
            drop_hole(p);
        end else if (lo) begin
            hole_len[p-1] = hole_len[p-1] + n;
        end else if (hi) begin
            hole_start[p] = s;
            hole_len[p] = hole_len[p] + n;
        end else if (hole_count < NHOLE) begin
            for (int i = hole_count; i > p; i--) begin
                hole_start[i] = hole_start[i-1];
                hole_len[i] = hole_len[i-1];
            end
            hole_start[p] = s;
            hole_len[p] = n;
            hole_count++;
        end
    endfunction

    function automatic alloc_reply_t predict_reply(logic cmd, data_t rsz, data_t pid);
        alloc_reply_t r;
        int slot, pick;
        r = '0;
        slot = -1;
        pick = -1;
        if (cmd == CMD_ALLOC) begin
            if (rsz == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            for (int i = 0; i < NOWN; i++)
                if (!own_live[i] && slot < 0) slot = i;
            if (slot < 0) begin
                r.status = ST_FULL;
                return r;
            end
            for (int i = 0; i < hole_count; i++)
                if (hole_len[i] >= rsz) begin
                    if (!fit_best) begin
                        if (pick < 0) pick = i;
                    end else if (pick < 0 || hole_len[i] < hole_len[pick]) begin
                        pick = i;
                    end
                end
            if (pick < 0) begin
                r.status = ST_NO_FIT;
                return r;
            end
            r.start = hole_start[pick];
            if (hole_len[pick] == rsz) drop_hole(pick);
            else begin
                hole_start[pick] += rsz;
                hole_len[pick] -= rsz;
            end
            own_live[slot] = 1'b1;
            own_id[slot] = id_next;
            own_start[slot] = r.start;
            own_len[slot] = rsz;
            r.status = ST_OK;
            r.id = id_next;
            r.size = rsz;
            live_ids.push_back(id_next);
            id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
            return r;
        end
        for (int i = 0; i < NOWN; i++)
            if (own_live[i] && own_id[i] == pid && slot < 0) slot = i;
        if (slot < 0) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        own_live[slot] = 1'b0;
        return_hole(own_start[slot], own_len[slot]);
        foreach (live_ids[k])
            if (live_ids[k] == pid) begin
                live_ids.delete(k);
                break;
            end
        r.status = ST_OK;
        r.id = pid;
        r.start = own_start[slot];
        r.size = own_len[slot];
        return r;
    endfunction

    // result checker with random back-pressure
    initial begin
        alloc_reply_t exp;
        int hold;
        forever begin
            @(negedge aclk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (!stream_busy) hold = 0;
            repeat (hold) @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (replies_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp = replies_due.pop_front();
                if (m_status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, m_status);
                    errors++;
                end
                if (m_result_id !== exp.id) begin
                    $error("result_id exp %0d got %0d", exp.id, m_result_id);
                    errors++;
                end
                if (m_base_addr !== exp.start) begin
                    $error("base_addr exp %0d got %0d", exp.start, m_base_addr);
                    errors++;
                end
                if (m_block_size !== exp.size) begin
                    $error("block_size exp %0d got %0d", exp.size, m_block_size);
                    errors++;
                end
            end
            @(negedge aclk);
            m_ready <= 1'b0;
        end
    end

    task automatic send_word(logic cmd, data_t rsz, data_t pid, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        repeat (gap + 1) @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_request_size <= rsz;
        s_proc_id <= pid;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(predict_reply(cmd, rsz, pid));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (replies_due.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, data_t value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= (idx == REG_MEM_SIZE) ? 3'd4 : 3'd0;
        pwdata <= {16'($urandom_range(0, 65535)), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_FIT_MODE) fit_best = value[0];
        else begin
            mem_units = value;
            wipe_tables();
        end
    endtask

    function automatic data_t pick_free_id();
        if (live_ids.size() != 0 && $urandom_range(0, 7) != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        return data_t'($urandom_range(0, 65535));
    endfunction

    task automatic test_directed();
        send_word(CMD_ALLOC, 16'd0, 16'hFFFF);
        send_word(CMD_FREE, 16'hFFFF, 16'd0);
        send_word(CMD_FREE, 16'd0, 16'hFFFF);
        send_word(CMD_ALLOC, 16'hFFFF, 16'd0);
        send_word(CMD_ALLOC, 16'd100, 16'd0, 0);
        send_word(CMD_ALLOC, 16'd200, 16'd0, 0);
        send_word(CMD_ALLOC, 16'd100, 16'd0, 0);
        send_word(CMD_FREE, 16'd0, 16'd1);
        send_word(CMD_FREE, 16'd0, 16'd3);
        send_word(CMD_FREE, 16'd0, 16'd2);
        for (int i = 0; i < NOWN + 1; i++) send_word(CMD_ALLOC, 16'd1, 16'd0, 0);
        for (int i = 4; i < 4 + NOWN; i++) send_word(CMD_FREE, 16'd0, data_t'(i), 0);
    endtask

    task automatic test_best_fit();
        write_reg(REG_FIT_MODE, 16'd1);
        for (int i = 0; i < 6; i++) send_word(CMD_ALLOC, data_t'(50 + 10 * i), 16'd0);
        send_word(CMD_FREE, 16'd0, id_next - 16'd6);
        send_word(CMD_FREE, 16'd0, id_next - 16'd4);
        send_word(CMD_ALLOC, 16'd40, 16'd0);
        send_word(CMD_ALLOC, 16'd50, 16'd0);
    endtask

    task automatic test_memory_extremes();
        write_reg(REG_MEM_SIZE, 16'd0);
        send_word(CMD_ALLOC, 16'd1, 16'd0);
        write_reg(REG_MEM_SIZE, 16'd1);
        send_word(CMD_ALLOC, 16'd1, 16'd0);
        send_word(CMD_ALLOC, 16'd1, 16'd0);
        write_reg(REG_MEM_SIZE, 16'hFFFF);
        send_word(CMD_ALLOC, 16'hFFFF, 16'd0);
        send_word(CMD_FREE, 16'd0, id_next - 16'd1);
    endtask

    task automatic random_phase(int count, int max_req);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 5 || live_ids.size() == 0)
                send_word(CMD_ALLOC,
                          ($urandom_range(0, 30) == 0) ? data_t'(0) :
                          ($urandom_range(0, 30) == 0) ? data_t'($urandom_range(0, 65535)) :
                          data_t'($urandom_range(1, max_req)),
                          data_t'($urandom_range(0, 65535)),
                          $urandom_range(0, 3) != 0);
            else
                send_word(CMD_FREE, data_t'($urandom_range(0, 65535)), pick_free_id(),
                          $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_random();
        write_reg(REG_FIT_MODE, 16'd0);
        write_reg(REG_MEM_SIZE, 16'd1024);
        random_phase(200, 120);
        write_reg(REG_FIT_MODE, 16'd1);
        random_phase(200, 120);
        write_reg(REG_MEM_SIZE, 16'hFFFF);
        random_phase(150, 16000);
        write_reg(REG_FIT_MODE, 16'd0);
        write_reg(REG_MEM_SIZE, 16'd37);
        random_phase(100, 8);
    endtask

    initial begin
        fit_best = 1'b0;
        mem_units = MEM_SIZE_RESET;
        id_next = 16'd1;
        wipe_tables();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        stream_busy = 1'b1;
        test_directed();
        test_best_fit();
        test_memory_extremes();
        test_random();
        drain();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
